/* sv/midpoint_circle_rasterizer_assert.svh */
// Assertion macros shared by the circle rasterizer modules.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH

// Checks a consequent in the same cycle as its antecedent.
`define MCR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rasterizer same-cycle check failed");

// Checks a consequent in the cycle after its antecedent.
`define MCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rasterizer next-cycle check failed");

`endif

/* sv/mcr_pkg.sv */
// Types and constants shared by the circle rasterizer modules.
`default_nettype none
package mcr_pkg;

  localparam int RAD_W   = 10;
  localparam int DEC_W   = 14;
  localparam int FRAME_W = 13;
  localparam int PIX_W   = 12;
  localparam int COORD_W = 14;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // One octant point together with the end-of-walk flag of its step.
  typedef struct packed {
    logic [RAD_W-1:0] x;
    logic [RAD_W-1:0] y;
    logic             done;
  } step_rec_t;

  // Effective frame size after clamping.
  typedef struct packed {
    logic [FRAME_W-1:0] w;
    logic [FRAME_W-1:0] h;
  } frame_t;

endpackage
`default_nettype wire

/* sv/midpoint_circle_rasterizer.sv */
// Top level of the midpoint circle rasterizer: configuration registers and the two ends.
`default_nettype none
// A start item loads a radius; it produces no points. Each advance item accepted during
// a walk produces eight mirrored points of the current octant point, one point per cycle
// while the output is taken, all from the single point emitter. Inputs are taken every
// cycle while the two-entry step queue between the decision walker and the emitter has
// room. The emitter stalls while a finished point waits in its output register and is not
// taken. Frame size writes go to cfg_index 0 (width) and 1 (height); sizes of zero act as
// one and sizes above MAX_FRAME saturate.
module midpoint_circle_rasterizer
  import mcr_pkg::*;
#(
  parameter int MAX_RADIUS = 1023,
  parameter int MAX_FRAME  = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic                 in_kind,
  input  wire logic [RAD_W-1:0]     in_radius,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic [PIX_W-1:0]          out_pix_x,
  output logic [PIX_W-1:0]          out_pix_y,
  output logic                      out_in_frame,
  output logic                      out_last_of_step,
  output logic                      out_circle_done,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FRAME_W-1:0]   cfg_data
);

  localparam int CMP_W = 18;

  logic [FRAME_W-1:0] frame_w_r, frame_w_nxt;
  logic [FRAME_W-1:0] frame_h_r, frame_h_nxt;
  frame_t             frame;
  logic               accept, out_valid, q_full, q_push, q_pop, q_valid;
  step_rec_t          q_in, q_head;

  function automatic logic [FRAME_W-1:0] clamp_frame(input logic [FRAME_W-1:0] v);
    logic [FRAME_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = FRAME_W'(1);
    end else if ({{(CMP_W-FRAME_W){1'b0}}, v} > CMP_W'(MAX_FRAME)) begin
      res = FRAME_W'(MAX_FRAME);
    end
    return res;
  endfunction

  assign cfg_ready = 1'b1;

  always_comb begin
    frame_w_nxt = frame_w_r;
    frame_h_nxt = frame_h_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_w_nxt = cfg_data;
        REG_FRAME_HEIGHT: frame_h_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= FRAME_W'(256);
      frame_h_r <= FRAME_W'(256);
    end else begin
      frame_w_r <= frame_w_nxt;
      frame_h_r <= frame_h_nxt;
    end
  end

  assign frame.w = clamp_frame(frame_w_r);
  assign frame.h = clamp_frame(frame_h_r);

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  mcr_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .kind     (in_kind),
    .radius   (in_radius),
    .rec_push (q_push),
    .rec      (q_in)
  );

  mcr_step_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_rec   (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_rec   (q_head),
    .head_valid (q_valid)
  );

  mcr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame        (frame),
    .head_valid   (q_valid),
    .head_rec     (q_head),
    .head_pop     (q_pop),
    .out_valid    (out_valid),
    .out_take     (out_pop),
    .pix_x        (out_pix_x),
    .pix_y        (out_pix_y),
    .in_frame     (out_in_frame),
    .last_of_step (out_last_of_step),
    .circle_done  (out_circle_done)
  );

  assign out_empty = !out_valid;

endmodule
`default_nettype wire

/* sv/mcr_step_queue.sv */
// Short queue of octant steps between the walker and the point emitter.
`default_nettype none
module mcr_step_queue
  import mcr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire step_rec_t push_rec,
  output logic           full,
  input  wire logic      pop,
  output step_rec_t      head_rec,
  output logic           head_valid
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  step_rec_t          q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               push_en, pop_en;

  assign full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_rec   = q_r[rd_ptr_r];
  assign push_en    = push && !full;
  assign pop_en     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_en && !pop_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_en && !push_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      q_r[wr_ptr_r] <= push_rec;
    end
  end

`include "midpoint_circle_rasterizer_assert.svh"

  `MCR_ASSERT_SAME(a_cnt_bounded, 1'b1, cnt_r <= CNT_W'(QUEUE_DEPTH))
  `MCR_ASSERT_NEXT(a_cnt_grows, push_en && !pop_en, cnt_r == $past(cnt_r) + 1'b1)

endmodule
`default_nettype wire

/* sv/mcr_front.sv */
// Front end: accepts items, runs the midpoint decision walk and queues octant steps.
`default_nettype none
module mcr_front
  import mcr_pkg::*;
#(
  parameter int MAX_RADIUS = 1023
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic             kind,
  input  wire logic [RAD_W-1:0] radius,
  output logic                  rec_push,
  output step_rec_t             rec
);

  localparam int CMP_W = 17;
  localparam int SUM_W = DEC_W + 2;

  logic [RAD_W-1:0]        x_r, x_nxt;
  logic [RAD_W-1:0]        y_r, y_nxt;
  logic signed [DEC_W-1:0] dec_r, dec_nxt;
  logic                    busy_r, busy_nxt;

  logic [RAD_W-1:0]        r_sat;
  logic signed [DEC_W-1:0] dec_start;
  logic signed [SUM_W-1:0] dec_ext, inc_neg, inc_pos, dec_step;
  logic signed [RAD_W:0]   diff;
  logic [RAD_W-1:0]        x_step, y_step;
  logic                    step_done;

  // Radius saturates at the configured maximum.
  assign r_sat = ({{(CMP_W-RAD_W){1'b0}}, radius} > CMP_W'(MAX_RADIUS)) ?
                 RAD_W'(MAX_RADIUS) : radius;
  assign dec_start = DEC_W'($signed(DEC_W'(3)) - $signed({3'b000, r_sat, 1'b0}));

  assign dec_ext = SUM_W'(dec_r);
  assign inc_neg = $signed({{(SUM_W-RAD_W-2){1'b0}}, x_r, 2'b00}) + SUM_W'(6);
  assign diff    = $signed({1'b0, x_r}) - $signed({1'b0, y_r});
  assign inc_pos = $signed({{(SUM_W-RAD_W-3){diff[RAD_W]}}, diff, 2'b00}) + SUM_W'(10);
  assign dec_step = dec_r[DEC_W-1] ? dec_ext + inc_neg : dec_ext + inc_pos;
  assign y_step   = dec_r[DEC_W-1] ? y_r : y_r - 1'b1;
  assign x_step   = x_r + 1'b1;
  assign step_done = (x_step > y_step);

  assign rec_push = accept && (kind == KIND_ADVANCE) && busy_r;
  assign rec.x    = x_r;
  assign rec.y    = y_r;
  assign rec.done = step_done;

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    dec_nxt  = dec_r;
    busy_nxt = busy_r;
    if (accept) begin
      if (kind == KIND_START) begin
        x_nxt    = '0;
        y_nxt    = r_sat;
        dec_nxt  = (r_sat == '0) ? '0 : dec_start;
        busy_nxt = (r_sat != '0);
      end else if (busy_r) begin
        x_nxt    = x_step;
        y_nxt    = y_step;
        dec_nxt  = DEC_W'(dec_step);
        busy_nxt = !step_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      dec_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      dec_r  <= dec_nxt;
      busy_r <= busy_nxt;
    end
  end

`include "midpoint_circle_rasterizer_assert.svh"

  `MCR_ASSERT_NEXT(a_done_goes_idle, rec_push && rec.done, !busy_r)
  `MCR_ASSERT_SAME(a_walk_in_octant, busy_r, x_r <= y_r)

endmodule
`default_nettype wire

/* sv/mcr_back.sv */
// Back end: expands each octant step into eight mirrored, centered and clipped points.
`default_nettype none
module mcr_back
  import mcr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire frame_t           frame,
  input  wire logic             head_valid,
  input  wire step_rec_t        head_rec,
  output logic                  head_pop,
  output logic                  out_valid,
  input  wire logic             out_take,
  output logic [PIX_W-1:0]      pix_x,
  output logic [PIX_W-1:0]      pix_y,
  output logic                  in_frame,
  output logic                  last_of_step,
  output logic                  circle_done
);

  logic [2:0]                k_r;
  logic                      valid_r;
  logic [PIX_W-1:0]          pix_x_r, pix_y_r;
  logic                      in_frame_r, last_r, done_r;

  logic                      load;
  logic [RAD_W-1:0]          a, b;
  logic signed [COORD_W-1:0] px, py, cx, cy;
  logic                      in_x, in_y, pt_in, last_pt;

  assign load    = head_valid && (!valid_r || out_take);
  assign last_pt = (k_r == 3'd7);
  assign head_pop = load && last_pt;

  // Bit 2 of the point index swaps x and y, bit 0 negates x, bit 1 negates y.
  assign a  = k_r[2] ? head_rec.y : head_rec.x;
  assign b  = k_r[2] ? head_rec.x : head_rec.y;
  assign px = k_r[0] ? -$signed({{(COORD_W-RAD_W){1'b0}}, a}) :
                        $signed({{(COORD_W-RAD_W){1'b0}}, a});
  assign py = k_r[1] ? -$signed({{(COORD_W-RAD_W){1'b0}}, b}) :
                        $signed({{(COORD_W-RAD_W){1'b0}}, b});
  assign cx = px + $signed({{(COORD_W-FRAME_W+1){1'b0}}, frame.w[FRAME_W-1:1]});
  assign cy = py + $signed({{(COORD_W-FRAME_W+1){1'b0}}, frame.h[FRAME_W-1:1]});
  assign in_x = !cx[COORD_W-1] && (cx < $signed({{(COORD_W-FRAME_W){1'b0}}, frame.w}));
  assign in_y = !cy[COORD_W-1] && (cy < $signed({{(COORD_W-FRAME_W){1'b0}}, frame.h}));
  assign pt_in = in_x && in_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      valid_r <= 1'b0;
    end else if (load) begin
      k_r     <= k_r + 1'b1;
      valid_r <= 1'b1;
    end else if (out_take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_x_r    <= pt_in ? cx[PIX_W-1:0] : '0;
      pix_y_r    <= pt_in ? cy[PIX_W-1:0] : '0;
      in_frame_r <= pt_in;
      last_r     <= last_pt;
      done_r     <= last_pt && head_rec.done;
    end
  end

  assign out_valid    = valid_r;
  assign pix_x        = pix_x_r;
  assign pix_y        = pix_y_r;
  assign in_frame     = in_frame_r;
  assign last_of_step = last_r;
  assign circle_done  = done_r;

`include "midpoint_circle_rasterizer_assert.svh"

  `MCR_ASSERT_SAME(a_done_on_last, valid_r && done_r, last_r)
  `MCR_ASSERT_NEXT(a_last_wraps, load && last_pt, k_r == 3'd0)

endmodule
`default_nettype wire
